/* rtl/svpwm_pkg.sv */
// Shared widths, sector codes and fixed-point constant helpers for the SVPWM core.
`timescale 1ns / 1ps

package svpwm_pkg;

    // Fixed field widths of the streaming payload
    localparam int VOLT_W   = 16;
    localparam int BUS_W    = 15;
    localparam int PERIOD_W = 16;
    localparam int SECTOR_W = 3;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

    // Sector codes; zero marks a zero bus voltage
    localparam logic [SECTOR_W-1:0] SECTOR_NONE = 3'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_1    = 3'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_2    = 3'd2;
    localparam logic [SECTOR_W-1:0] SECTOR_3    = 3'd3;
    localparam logic [SECTOR_W-1:0] SECTOR_4    = 3'd4;
    localparam logic [SECTOR_W-1:0] SECTOR_5    = 3'd5;
    localparam logic [SECTOR_W-1:0] SECTOR_6    = 3'd6;

    // Q30 values of 1/sqrt(3) and 2/sqrt(3)
    localparam longint Q30_ONE_BY_SQRT3 = 64'd619925131;
    localparam longint Q30_TWO_BY_SQRT3 = 64'd1239850262;

    // Round a Q30 constant to nearest at the given fraction width
    function automatic logic [31:0] q30_round(input longint q30, input int frac);
        longint r;
        begin
            r = (q30 + (longint'(1) << (29 - frac))) >>> (30 - frac);
            return r[31:0];
        end
    endfunction

endpackage

/* rtl/space_vector_pwm_core.sv */
// Seven-segment space vector PWM core: normalize, sector, vector times, compare values.
// Each input passes through the divider pipeline, then the core stages, to the result.
// Throughput: one item per cycle while m_tready is high; a one-bit-per-stage divider
// pipeline sets the depth. Each stage holds alone; input stalls only when all are full.
// Reset (rst_n low, asynchronous) empties the pipeline and loads a period of 1000.
`timescale 1ns / 1ps

module space_vector_pwm_core #(
    parameter int FRAC_BITS = 15
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [svpwm_pkg::PERIOD_W-1:0]    cfg_wdata,    // PWM period in ticks
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [svpwm_pkg::S_TDATA_W-1:0]   s_tdata,      // v_alpha, v_beta, v_bus
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [svpwm_pkg::M_TDATA_W-1:0]   m_tdata       // duty_u, duty_v, duty_w,
                                                            // sector_num, clamped
);
    import svpwm_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int KW   = F + 2;                 // kb and tb
    localparam int XW   = F + 3;                 // time arguments
    localparam int PK_W = 2 * F + 3;             // constant products
    localparam int PX_W = XW + PERIOD_W + 1;     // time products
    localparam int TW   = PERIOD_W + 3;          // vector times
    localparam int HW   = PERIOD_W + 4;          // compare sums

    localparam logic [31:0] C1_FULL = q30_round(Q30_ONE_BY_SQRT3, F);
    localparam logic [31:0] C2_FULL = q30_round(Q30_TWO_BY_SQRT3, F);
    localparam logic signed [F+1:0] C1 = $signed({1'b0, C1_FULL[F:0]});
    localparam logic signed [F+1:0] C2 = $signed({1'b0, C2_FULL[F:0]});
    localparam logic [PK_W-1:0] RND_K = {{(PK_W-F){1'b0}}, {F{1'b1}}};
    localparam logic [PX_W-1:0] RND_X = {{(PX_W-F){1'b0}}, {F{1'b1}}};

    // Hold the period register
    logic [PERIOD_W-1:0] period_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= PERIOD_RESET;
        else if (cfg_we)
            period_reg <= cfg_wdata;
    end

    // Normalize the commands
    logic                 dv_valid;
    logic                 dv_ready;
    logic signed [F:0]    norm_a;
    logic signed [F:0]    norm_b;
    logic                 bus_zero;

    svpwm_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .v_alpha   (s_tdata[15:0]),
        .v_beta    (s_tdata[31:16]),
        .v_bus     (s_tdata[46:32]),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .norm_a    (norm_a),
        .norm_b    (norm_b),
        .bus_zero  (bus_zero)
    );

    // Stage valid bits and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic r1, r2, r3, r4, r5;
    assign r5       = !v5_reg || m_tready;
    assign r4       = !v4_reg || r5;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign dv_ready = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= dv_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
            if (r5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: scale beta by the root-three constants
    logic signed [PK_W-1:0] pk_reg, pt_reg;
    logic signed [F:0]      a1_reg;
    logic                   z1_reg;
    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            pk_reg <= PK_W'($signed(norm_b) * C1);
            pt_reg <= PK_W'($signed(norm_b) * C2);
            a1_reg <= norm_a;
            z1_reg <= bus_zero;
        end
    end

    // Stage 2: truncate, pick the sector and the time arguments
    logic signed [PK_W-1:0] pk_adj, pt_adj;
    logic signed [KW-1:0]   kb, tb;
    logic signed [XW-1:0]   ax, kx, tx;
    logic signed [XW-1:0]   x1, x2;
    logic [SECTOR_W-1:0]    sector;

    always_comb
    begin
        pk_adj = pk_reg + (pk_reg[PK_W-1] ? $signed(RND_K) : '0);
        pt_adj = pt_reg + (pt_reg[PK_W-1] ? $signed(RND_K) : '0);
        kb     = KW'(pk_adj >>> F);
        tb     = KW'(pt_adj >>> F);
        ax     = XW'(a1_reg);
        kx     = XW'(kb);
        tx     = XW'(tb);
        if (!a1_reg[F] && !kb[KW-1] && kx > ax)
            sector = SECTOR_2;
        else if (!tb[KW-1] && !a1_reg[F])
            sector = SECTOR_1;
        else if (!tb[KW-1])
            sector = (-kx > ax) ? SECTOR_3 : SECTOR_2;
        else if (!a1_reg[F])
            sector = (-kx > ax) ? SECTOR_5 : SECTOR_6;
        else
            sector = (kx > ax) ? SECTOR_4 : SECTOR_5;
        case (sector)
            SECTOR_1: begin x1 = ax - kx;  x2 = tx;       end
            SECTOR_2: begin x1 = ax + kx;  x2 = kx - ax;  end
            SECTOR_3: begin x1 = tx;       x2 = -ax - kx; end
            SECTOR_4: begin x1 = kx - ax;  x2 = -tx;      end
            SECTOR_5: begin x1 = -ax - kx; x2 = ax - kx;  end
            default:  begin x1 = -tx;      x2 = ax + kx;  end
        endcase
    end

    logic signed [XW-1:0] x1_reg, x2_reg;
    logic [SECTOR_W-1:0]  sec2_reg;
    logic                 z2_reg;
    always_ff @(posedge clk)
    begin
        if (r2)
        begin
            x1_reg   <= x1;
            x2_reg   <= x2;
            sec2_reg <= z1_reg ? SECTOR_NONE : sector;
            z2_reg   <= z1_reg;
        end
    end

    // Stage 3: multiply by the period
    logic signed [PERIOD_W:0] per_s;
    assign per_s = $signed({1'b0, period_reg});

    logic signed [PX_W-1:0] p1_reg, p2_reg;
    logic [SECTOR_W-1:0]    sec3_reg;
    logic                   z3_reg;
    always_ff @(posedge clk)
    begin
        if (r3)
        begin
            p1_reg   <= PX_W'(x1_reg * per_s);
            p2_reg   <= PX_W'(x2_reg * per_s);
            sec3_reg <= sec2_reg;
            z3_reg   <= z2_reg;
        end
    end

    // Stage 4: truncate the times and form the centered sum
    logic signed [PX_W-1:0] p1_adj, p2_adj;
    logic signed [TW-1:0]   t1, t2;
    always_comb
    begin
        p1_adj = p1_reg + (p1_reg[PX_W-1] ? $signed(RND_X) : '0);
        p2_adj = p2_reg + (p2_reg[PX_W-1] ? $signed(RND_X) : '0);
        t1     = TW'(p1_adj >>> F);
        t2     = TW'(p2_adj >>> F);
    end

    logic signed [TW-1:0] t1_reg, t2_reg;
    logic signed [HW-1:0] sum_reg;
    logic [SECTOR_W-1:0]  sec4_reg;
    logic                 z4_reg;
    always_ff @(posedge clk)
    begin
        if (r4)
        begin
            t1_reg   <= t1;
            t2_reg   <= t2;
            sum_reg  <= HW'(per_s) + HW'(t1) + HW'(t2);
            sec4_reg <= sec3_reg;
            z4_reg   <= z3_reg;
        end
    end

    // Stage 5: halve, order the phases, saturate; a zero bus gives half the period on every phase
    logic signed [HW-1:0]   half, d1, d2, d12, cu, cv, cw;
    logic [PERIOD_W-1:0]    du, dv, dw;
    logic                   fu, fv, fw;
    always_comb
    begin
        half = (sum_reg + HW'(sum_reg[HW-1])) >>> 1;
        d1   = half - HW'(t1_reg);
        d2   = half - HW'(t2_reg);
        d12  = d1 - HW'(t2_reg);
        case (sec4_reg)
            SECTOR_1: begin cu = half; cv = d1;   cw = d12;  end
            SECTOR_2: begin cu = d2;   cv = half; cw = d12;  end
            SECTOR_3: begin cu = d12;  cv = half; cw = d1;   end
            SECTOR_4: begin cu = d12;  cv = d2;   cw = half; end
            SECTOR_5: begin cu = d1;   cv = d12;  cw = half; end
            default:  begin cu = half; cv = d12;  cw = d2;   end
        endcase
        fu = cu[HW-1] || (cu > HW'(per_s));
        fv = cv[HW-1] || (cv > HW'(per_s));
        fw = cw[HW-1] || (cw > HW'(per_s));
        du = cu[HW-1] ? '0 : (fu ? period_reg : cu[PERIOD_W-1:0]);
        dv = cv[HW-1] ? '0 : (fv ? period_reg : cv[PERIOD_W-1:0]);
        dw = cw[HW-1] ? '0 : (fw ? period_reg : cw[PERIOD_W-1:0]);
    end

    logic [PERIOD_W-1:0] du_reg, dv_reg, dw_reg;
    logic [SECTOR_W-1:0] sec5_reg;
    logic                flag_reg;
    always_ff @(posedge clk)
    begin
        if (r5)
        begin
            if (z4_reg)
            begin
                du_reg   <= period_reg >> 1;
                dv_reg   <= period_reg >> 1;
                dw_reg   <= period_reg >> 1;
                flag_reg <= 1'b1;
            end
            else
            begin
                du_reg   <= du;
                dv_reg   <= dv;
                dw_reg   <= dw;
                flag_reg <= fu || fv || fw;
            end
            sec5_reg <= sec4_reg;
        end
    end

    // Drive the result channel
    assign m_tvalid = v5_reg;
    assign m_tdata  = {4'b0000, flag_reg, sec5_reg, dw_reg, dv_reg, du_reg};

endmodule

/* rtl/svpwm_div.sv */
// Pipelined restoring divider that normalizes alpha and beta by the bus voltage.
`timescale 1ns / 1ps

module svpwm_div #(
    parameter int FRAC_BITS = 15
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [svpwm_pkg::VOLT_W-1:0] v_alpha,
    input  logic signed [svpwm_pkg::VOLT_W-1:0] v_beta,
    input  logic [svpwm_pkg::BUS_W-1:0]      v_bus,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [FRAC_BITS:0]        norm_a,
    output logic signed [FRAC_BITS:0]        norm_b,
    output logic                             bus_zero
);
    import svpwm_pkg::*;

    localparam int NS = FRAC_BITS + 1;

    logic             valid_reg [0:FRAC_BITS];
    logic             ready     [0:NS];
    logic [BUS_W-1:0] bus_reg   [0:FRAC_BITS];
    logic [BUS_W-1:0] rem_a_reg [0:FRAC_BITS];
    logic [BUS_W-1:0] rem_b_reg [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] q_a_reg [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] q_b_reg [0:FRAC_BITS];
    logic             neg_a_reg [0:FRAC_BITS];
    logic             neg_b_reg [0:FRAC_BITS];
    logic             sat_a_reg [0:FRAC_BITS];
    logic             sat_b_reg [0:FRAC_BITS];

    logic [VOLT_W-1:0] mag_a;
    logic [VOLT_W-1:0] mag_b;

    // Chain ready from the output back to the input
    assign ready[NS] = out_ready;
    genvar k;
    generate
        for (k = 0; k <= FRAC_BITS; k++)
        begin : g_ready
            assign ready[k] = !valid_reg[k] || ready[k+1];
        end
    endgenerate
    assign in_ready = ready[0];

    // Take magnitudes of the commands
    assign mag_a = v_alpha[VOLT_W-1] ? (~v_alpha + 1'b1) : v_alpha;
    assign mag_b = v_beta[VOLT_W-1]  ? (~v_beta + 1'b1)  : v_beta;

    // Load the first stage and flag out-of-range quotients
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (ready[0])
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            bus_reg[0]   <= v_bus;
            rem_a_reg[0] <= mag_a[BUS_W-1:0];
            rem_b_reg[0] <= mag_b[BUS_W-1:0];
            q_a_reg[0]   <= '0;
            q_b_reg[0]   <= '0;
            neg_a_reg[0] <= v_alpha[VOLT_W-1];
            neg_b_reg[0] <= v_beta[VOLT_W-1];
            sat_a_reg[0] <= mag_a >= {1'b0, v_bus};
            sat_b_reg[0] <= mag_b >= {1'b0, v_bus};
        end
    end

    // One quotient bit per stage for each lane
    generate
        for (k = 1; k <= FRAC_BITS; k++)
        begin : g_step
            logic [BUS_W:0] sh_a;
            logic [BUS_W:0] sh_b;
            logic [BUS_W:0] df_a;
            logic [BUS_W:0] df_b;
            logic           ge_a;
            logic           ge_b;

            assign sh_a = {rem_a_reg[k-1], 1'b0};
            assign sh_b = {rem_b_reg[k-1], 1'b0};
            assign ge_a = sh_a >= {1'b0, bus_reg[k-1]};
            assign ge_b = sh_b >= {1'b0, bus_reg[k-1]};
            assign df_a = sh_a - {1'b0, bus_reg[k-1]};
            assign df_b = sh_b - {1'b0, bus_reg[k-1]};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (ready[k])
                begin
                    bus_reg[k]   <= bus_reg[k-1];
                    rem_a_reg[k] <= ge_a ? df_a[BUS_W-1:0] : sh_a[BUS_W-1:0];
                    rem_b_reg[k] <= ge_b ? df_b[BUS_W-1:0] : sh_b[BUS_W-1:0];
                    q_a_reg[k]   <= {q_a_reg[k-1][FRAC_BITS-2:0], ge_a};
                    q_b_reg[k]   <= {q_b_reg[k-1][FRAC_BITS-2:0], ge_b};
                    neg_a_reg[k] <= neg_a_reg[k-1];
                    neg_b_reg[k] <= neg_b_reg[k-1];
                    sat_a_reg[k] <= sat_a_reg[k-1];
                    sat_b_reg[k] <= sat_b_reg[k-1];
                end
            end
        end
    endgenerate

    // Apply sign and saturation to the quotients
    localparam logic signed [FRAC_BITS:0] Q_MAX = {1'b0, {FRAC_BITS{1'b1}}};
    localparam logic signed [FRAC_BITS:0] Q_MIN = {1'b1, {FRAC_BITS{1'b0}}};

    logic signed [FRAC_BITS:0] qa_ext;
    logic signed [FRAC_BITS:0] qb_ext;

    assign qa_ext = $signed({1'b0, q_a_reg[FRAC_BITS]});
    assign qb_ext = $signed({1'b0, q_b_reg[FRAC_BITS]});

    always_comb
    begin
        if (sat_a_reg[FRAC_BITS])
            norm_a = neg_a_reg[FRAC_BITS] ? Q_MIN : Q_MAX;
        else
            norm_a = neg_a_reg[FRAC_BITS] ? -qa_ext : qa_ext;
        if (sat_b_reg[FRAC_BITS])
            norm_b = neg_b_reg[FRAC_BITS] ? Q_MIN : Q_MAX;
        else
            norm_b = neg_b_reg[FRAC_BITS] ? -qb_ext : qb_ext;
    end

    assign bus_zero  = bus_reg[FRAC_BITS] == '0;
    assign out_valid = valid_reg[FRAC_BITS];

endmodule
